@@ rtl/core/u8d_pkg.sv @@
// shared types and constants for the utf-8 stream decoder
package u8d_pkg;

  localparam logic [20:0] REPL_CP  = 21'h00FFFD;
  localparam logic [20:0] MAX_CP   = 21'h10FFFF;
  localparam logic [20:0] SURR_LO  = 21'h00D800;
  localparam logic [20:0] SURR_HI  = 21'h00DFFF;
  localparam logic [20:0] MIN_CP2  = 21'h000080;
  localparam logic [20:0] MIN_CP3  = 21'h000800;
  localparam logic [20:0] MIN_CP4  = 21'h010000;

  localparam logic [2:0]  LEN_NONE = 3'd0;
  localparam logic [2:0]  LEN_TWO  = 3'd2;
  localparam logic [2:0]  LEN_THREE = 3'd3;
  localparam logic [2:0]  LEN_FOUR = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } u8d_in_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        was_invalid;
    logic        last_of_run;
  } u8d_out_t;

  // one input byte's results: count-1 replacements, then the final result
  typedef struct packed {
    logic [2:0]  count;
    logic [20:0] cp;
    logic        bad;
  } u8d_desc_t;

endpackage

@@ rtl/core/u8d_decode.sv @@
// sequence state and per-byte decode into a result burst descriptor
module u8d_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  u8d_pkg::u8d_in_t  in_beat,
  output u8d_pkg::u8d_desc_t desc
);
  import u8d_pkg::*;

  logic [2:0]  exp_len_r, exp_len_nxt;
  logic [1:0]  held_r, held_nxt;
  logic [20:0] partial_r, partial_nxt;

  logic [7:0]  b;
  logic        eot;
  logic        is_cont;
  logic        is_ascii;
  logic [2:0]  lead_len;
  logic [20:0] lead_val;
  logic [20:0] pv_cat;
  logic [2:0]  held_inc;
  logic [2:0]  pre;
  logic [20:0] min_cp;
  logic        val_ok;
  logic        lead_go;

  assign b        = in_beat.in_byte;
  assign eot      = in_beat.end_of_text;
  assign is_cont  = (b[7:6] == 2'b10);
  assign is_ascii = ~b[7];
  assign pv_cat   = {partial_r[14:0], b[5:0]};
  assign held_inc = {1'b0, held_r} + 3'd1;

  always_comb begin
    lead_len = LEN_NONE;
    lead_val = '0;
    if (b[7:5] == 3'b110) begin
      lead_len = LEN_TWO;
      lead_val = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      lead_len = LEN_THREE;
      lead_val = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      lead_len = LEN_FOUR;
      lead_val = {18'd0, b[2:0]};
    end
  end

  always_comb begin
    case (exp_len_r)
      LEN_TWO:   min_cp = MIN_CP2;
      LEN_THREE: min_cp = MIN_CP3;
      default:   min_cp = MIN_CP4;
    endcase
  end

  assign val_ok = (pv_cat >= min_cp) && (pv_cat <= MAX_CP) &&
                  !((pv_cat >= SURR_LO) && (pv_cat <= SURR_HI));

  always_comb begin
    exp_len_nxt = exp_len_r;
    held_nxt    = held_r;
    partial_nxt = partial_r;
    desc.count  = 3'd0;
    desc.cp     = REPL_CP;
    desc.bad    = 1'b1;
    pre         = 3'd0;
    lead_go     = 1'b1;

    if (exp_len_r != LEN_NONE) begin
      if (is_cont) begin
        lead_go     = 1'b0;
        partial_nxt = pv_cat;
        held_nxt    = held_inc[1:0];
        if ((held_inc + 3'd1) >= exp_len_r) begin
          // form complete
          exp_len_nxt = LEN_NONE;
          held_nxt    = '0;
          partial_nxt = '0;
          if (val_ok) begin
            desc.count = 3'd1;
            desc.cp    = pv_cat;
            desc.bad   = 1'b0;
          end else begin
            desc.count = exp_len_r;
          end
        end else if (eot) begin
          // cut off at end of text
          exp_len_nxt = LEN_NONE;
          held_nxt    = '0;
          partial_nxt = '0;
          desc.count  = held_inc + 3'd1;
        end
      end else begin
        // broken sequence, then this byte starts over as a lead
        pre         = held_inc;
        exp_len_nxt = LEN_NONE;
        held_nxt    = '0;
        partial_nxt = '0;
      end
    end

    if (lead_go) begin
      if (is_ascii) begin
        desc.count = pre + 3'd1;
        desc.cp    = {13'd0, b};
        desc.bad   = 1'b0;
      end else if (lead_len != LEN_NONE) begin
        if (eot) begin
          desc.count = pre + 3'd1;
        end else begin
          desc.count  = pre;
          exp_len_nxt = lead_len;
          held_nxt    = '0;
          partial_nxt = lead_val;
        end
      end else begin
        desc.count = pre + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r <= LEN_NONE;
      held_r    <= '0;
      partial_r <= '0;
    end else if (in_fire) begin
      exp_len_r <= exp_len_nxt;
      held_r    <= held_nxt;
      partial_r <= partial_nxt;
    end
  end

endmodule

@@ rtl/core/u8d_emit.sv @@
// descriptor register and burst emitter toward the result channel
module u8d_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  u8d_pkg::u8d_desc_t  push_desc,
  output logic                push_ready,
  output logic                out_valid,
  input  logic                out_stall,
  output u8d_pkg::u8d_out_t   out_data
);
  import u8d_pkg::*;

  logic        desc_valid_r, desc_valid_nxt;
  u8d_desc_t   desc_r;
  logic        em_valid_r, em_valid_nxt;
  logic [2:0]  em_left_r, em_left_nxt;
  logic [20:0] em_cp_r;
  logic        em_bad_r;

  logic out_fire;
  logic em_last;
  logic em_free;
  logic desc_take;

  assign out_fire   = em_valid_r && !out_stall;
  assign em_last    = (em_left_r == 3'd1);
  assign em_free    = !em_valid_r || (out_fire && em_last);
  assign desc_take  = desc_valid_r && em_free;
  assign push_ready = !desc_valid_r || desc_take;

  assign out_valid            = em_valid_r;
  assign out_data.code_point  = em_last ? em_cp_r : REPL_CP;
  assign out_data.was_invalid = em_last ? em_bad_r : 1'b1;
  assign out_data.last_of_run = em_last;

  always_comb begin
    desc_valid_nxt = desc_valid_r;
    if (push) begin
      desc_valid_nxt = 1'b1;
    end else if (desc_take) begin
      desc_valid_nxt = 1'b0;
    end

    em_valid_nxt = em_valid_r;
    em_left_nxt  = em_left_r;
    if (desc_take) begin
      em_valid_nxt = 1'b1;
      em_left_nxt  = desc_r.count;
    end else if (out_fire) begin
      em_valid_nxt = !em_last;
      em_left_nxt  = em_left_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_valid_r <= 1'b0;
      em_valid_r   <= 1'b0;
      em_left_r    <= '0;
    end else begin
      desc_valid_r <= desc_valid_nxt;
      em_valid_r   <= em_valid_nxt;
      em_left_r    <= em_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      desc_r <= push_desc;
    end
    if (desc_take) begin
      em_cp_r  <= desc_r.cp;
      em_bad_r <= desc_r.bad;
    end
  end

endmodule

@@ rtl/core/utf8_stream_decoder.sv @@
// utf-8 stream decoder top level: byte channel in, code point channel out
//
// input channel: one text byte per beat (in_data.in_byte) with end_of_text
//   set on the final byte of a text; a beat is taken when in_valid is high
//   and in_stall is low
// output channel: one code point per beat, with was_invalid on replacement
//   characters (U+FFFD) and last_of_run on the final result of a byte
// an input byte yields zero to four results; bytes that only extend an open
//   sequence yield none and never occupy the output side
// path: a byte's results pass the descriptor, then the emitter register
// throughput: one byte per cycle while out_stall is low and each byte
//   yields at most one result; a byte with n results holds the emitter
//   until all n are out, and the descriptor register lets the next byte in
// reset: any partial sequence is dropped, both pipeline registers empty
// stall: while out_stall is high the current result holds; once the
//   descriptor register is also full, in_stall rises until the burst drains
module utf8_stream_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  u8d_pkg::u8d_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output u8d_pkg::u8d_out_t  out_data
);
  import u8d_pkg::*;

  u8d_desc_t desc;
  logic      push_ready;
  logic      in_fire;
  logic      push;

  assign in_stall = !push_ready;
  assign in_fire  = in_valid && push_ready;
  // only bytes that produce results take the descriptor slot
  assign push     = in_fire && (desc.count != 3'd0);

  // sequence state, updated on every accepted byte
  u8d_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_beat (in_data),
    .desc    (desc)
  );

  // burst serializer feeding the result channel
  u8d_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (desc),
    .push_ready (push_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

@@ tb/sv/utf8_stream_decoder_test.sv @@
// self-checking testbench for the utf-8 stream decoder
`timescale 1ns / 100ps

module utf8_stream_decoder_test;
  import u8d_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;   // long receiver hold-off, fills the block
  localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no beat on either side
  localparam int SETTLE_CYCLES   = 10;    // settle time after the final drain, before the verdict

  // how the random text is built, one form at a time
  typedef enum int {
    FORM_VALID,
    FORM_BAD_VALUE,
    FORM_TRUNCATED,
    FORM_BROKEN,
    FORM_NOISE
  } form_kind_t;

  // receiver stall patterns, switched when stall_phase[5:0] is zero
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  u8d_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  u8d_out_t out_data;

  // decoder state mirrored by the predictor
  logic [2:0]  dec_len = LEN_NONE;
  logic [1:0]  dec_held = 2'd0;
  logic [20:0] dec_partial = 21'd0;

  u8d_out_t    expected_cps[$];   // code points still owed by the block
  u8d_out_t    want_cp;
  logic [7:0]  text_bytes[$];     // bytes of the form about to be sent
  int          error_count = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;

  // receiver side
  stall_mode_t stall_mode = STALL_NONE;
  logic [7:0]  stall_phase = 8'd0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;

  utf8_stream_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: one accepted byte in, zero to four code points queued
  // ---------------------------------------------------------------------------
  task automatic predict_code_points(input logic [7:0] b, input logic eot);
    u8d_out_t    run[$];
    u8d_out_t    repl;
    u8d_out_t    beat;
    logic [20:0] floor_cp;
    logic [2:0]  lead_len;
    logic [20:0] lead_bits;
    logic        as_lead;
    logic        shut;
    repl     = '0;
    repl.code_point  = REPL_CP;
    repl.was_invalid = 1'b1;
    as_lead  = 1'b1;
    shut     = 1'b0;
    lead_len = LEN_NONE;
    lead_bits = 21'd0;
    if (dec_len != LEN_NONE) begin
      if (b[7:6] == 2'b10) begin
        // continuation: gather six more bits
        as_lead = 1'b0;
        dec_partial = {dec_partial[14:0], b[5:0]};
        dec_held = dec_held + 2'd1;
        if (int'(dec_held) + 1 >= int'(dec_len)) begin
          // form complete: check overlong, surrogate and range
          case (dec_len)
            LEN_TWO:   floor_cp = MIN_CP2;
            LEN_THREE: floor_cp = MIN_CP3;
            default:   floor_cp = MIN_CP4;
          endcase
          if (dec_partial < floor_cp || dec_partial > MAX_CP ||
              (dec_partial >= SURR_LO && dec_partial <= SURR_HI)) begin
            repeat (int'(dec_len)) run.push_back(repl);
          end else begin
            beat = '0;
            beat.code_point = dec_partial;
            run.push_back(beat);
          end
          shut = 1'b1;
        end else if (eot) begin
          // text ends inside the form: lead and every byte taken go bad
          repeat (int'(dec_held) + 1) run.push_back(repl);
          shut = 1'b1;
        end
      end else begin
        // not a continuation: flush the open form, reuse the byte as a lead
        repeat (int'(dec_held) + 1) run.push_back(repl);
        shut = 1'b1;
      end
    end
    if (shut) begin
      dec_len = LEN_NONE;
      dec_held = 2'd0;
      dec_partial = 21'd0;
    end
    if (as_lead) begin
      if (b[7] == 1'b0) begin
        beat = '0;
        beat.code_point = {13'd0, b};
        run.push_back(beat);
      end else if (b[7:5] == 3'b110) begin
        lead_len = LEN_TWO;
        lead_bits = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        lead_len = LEN_THREE;
        lead_bits = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        lead_len = LEN_FOUR;
        lead_bits = {18'd0, b[2:0]};
      end else begin
        // stray continuation or f8..ff
        run.push_back(repl);
      end
      if (lead_len != LEN_NONE) begin
        if (eot) begin
          run.push_back(repl);
        end else begin
          dec_len = lead_len;
          dec_held = 2'd0;
          dec_partial = lead_bits;
        end
      end
    end
    if (run.size() != 0) begin
      beat = run.pop_back();
      beat.last_of_run = 1'b1;
      run.push_back(beat);
    end
    foreach (run[i]) expected_cps.push_back(run[i]);
  endtask

  // ---------------------------------------------------------------------------
  // sender: bursts of random length with random gaps in between
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int   gap;
    logic taken;
    u8d_in_t beat;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      // now and then a long run with no idling at all
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
    end
    burst_left--;
    beat.in_byte = b;
    beat.end_of_text = eot;
    in_valid <= 1'b1;
    in_data <= beat;
    // stall is sampled mid-cycle, where it has settled for the coming edge
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    predict_code_points(b, eot);
  endtask

  // send the staged form, end_of_text on its last byte if asked
  task automatic send_text(input logic eot_last);
    foreach (text_bytes[i])
      send_byte(text_bytes[i], eot_last && (i == text_bytes.size() - 1));
    text_bytes.delete();
  endtask

  // sender idles until every owed code point has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_cps.size() != 0);
  endtask

  // stage one random form in text_bytes
  task automatic compose_form(input form_kind_t kind);
    int          len;
    int          pos;
    logic [20:0] cp;
    logic [7:0]  junk;
    text_bytes.delete();
    case (kind)
      FORM_NOISE: len = 0;
      FORM_VALID: len = $urandom_range(1, 4);
      default:    len = $urandom_range(2, 4);
    endcase
    if (kind == FORM_NOISE) begin
      text_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      if (kind == FORM_BAD_VALUE) begin
        // overlong, surrogate, or beyond the last scalar
        case (len)
          2: cp = 21'($urandom_range(0, 'h7F));
          3: cp = $urandom_range(0, 1) ? 21'($urandom_range(0, 'h7FF))
                                       : 21'($urandom_range('hD800, 'hDFFF));
          default: cp = $urandom_range(0, 1) ? 21'($urandom_range(0, 'hFFFF))
                                             : 21'($urandom_range('h110000, 'h1FFFFF));
        endcase
      end else begin
        case (len)
          1: cp = 21'($urandom_range(0, 'h7F));
          2: cp = 21'($urandom_range('h80, 'h7FF));
          3: begin
            cp = 21'($urandom_range('h800, 'hFFFF));
            if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h004000;
          end
          default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
      end
      case (len)
        1: text_bytes.push_back({1'b0, cp[6:0]});
        2: begin
          text_bytes.push_back({3'b110, cp[10:6]});
          text_bytes.push_back({2'b10, cp[5:0]});
        end
        3: begin
          text_bytes.push_back({4'b1110, cp[15:12]});
          text_bytes.push_back({2'b10, cp[11:6]});
          text_bytes.push_back({2'b10, cp[5:0]});
        end
        default: begin
          text_bytes.push_back({5'b11110, cp[20:18]});
          text_bytes.push_back({2'b10, cp[17:12]});
          text_bytes.push_back({2'b10, cp[11:6]});
          text_bytes.push_back({2'b10, cp[5:0]});
        end
      endcase
      if (kind == FORM_TRUNCATED) begin
        repeat ($urandom_range(1, len - 1)) void'(text_bytes.pop_back());
      end else if (kind == FORM_BROKEN) begin
        // swap one continuation for ascii, a lead, or an f8..ff byte
        pos = $urandom_range(1, len - 1);
        junk = 8'($urandom_range(0, 255));
        if (junk[7:6] == 2'b10) begin
          if ($urandom_range(0, 1)) junk[7] = 1'b0;
          else junk[6] = 1'b1;
        end
        text_bytes[pos] = junk;
      end
    end
  endtask

  // pick a form kind: well-formed with valid_pct percent chance, else one of the other four
  function automatic form_kind_t pick_kind(input int valid_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < valid_pct) return FORM_VALID;
    roll = $urandom_range(0, 3);
    case (roll)
      0:       return FORM_BAD_VALUE;
      1:       return FORM_TRUNCATED;
      2:       return FORM_BROKEN;
      default: return FORM_NOISE;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: own stall pattern, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    stall_phase <= stall_phase + 8'd1;
    if (stall_phase[5:0] == 6'd0) stall_mode <= stall_mode_t'($urandom_range(0, 3));
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_OFF_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_PERIODIC: out_stall <= stall_phase[2] & stall_phase[0];
        default:        out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // result checking, sampled mid-cycle ahead of the accepting edge
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got %0h, want %0h", what, got, want);
    error_count++;
  endtask

  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cps.size() == 0) begin
        report_mismatch("unexpected beat, code_point", out_data.code_point, 0);
      end else begin
        want_cp = expected_cps.pop_front();
        if (out_data.code_point !== want_cp.code_point)
          report_mismatch("code_point", out_data.code_point, want_cp.code_point);
        if (out_data.was_invalid !== want_cp.was_invalid)
          report_mismatch("was_invalid", out_data.was_invalid, want_cp.was_invalid);
        if (out_data.last_of_run !== want_cp.last_of_run)
          report_mismatch("last_of_run", out_data.last_of_run, want_cp.last_of_run);
      end
    end
  end

  // watchdog: too long without a beat on either side
  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // nul, top ascii, and the edges of the two, three and four byte forms
  task automatic test_valid_forms();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    text_bytes = '{8'hC2, 8'h80};
    send_text(1'b0);
    text_bytes = '{8'hEF, 8'hBF, 8'hBF};
    send_text(1'b0);
    text_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_text(1'b0);
  endtask

  // overlong from a c0 lead, surrogate, above the last scalar, a bad lead and a stray continuation
  task automatic test_invalid_values();
    text_bytes = '{8'hC0, 8'h80};
    send_text(1'b0);
    text_bytes = '{8'hED, 8'hA0, 8'h80};
    send_text(1'b0);
    text_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
    send_text(1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  // non-continuation mid-form, text cut inside a form, lead as final byte
  task automatic test_broken_sequences();
    text_bytes = '{8'hE2, 8'h41};
    send_text(1'b0);
    text_bytes = '{8'hF0, 8'h90};
    send_text(1'b1);
    send_byte(8'hC3, 1'b1);
  endtask

  // mostly well-formed text with random content, some noise, bad-value, truncated and broken forms
  task automatic test_random_text(input int n_bytes);
    int         sent;
    form_kind_t kind;
    logic       eot;
    sent = 0;
    while (sent < n_bytes) begin
      kind = pick_kind(60);
      compose_form(kind);
      eot = ($urandom_range(0, 7) == 0) ||
            (kind == FORM_TRUNCATED && $urandom_range(0, 1));
      sent += text_bytes.size();
      send_text(eot);
    end
  endtask

  // receiver holds off while the sender keeps going with error-heavy text
  task automatic test_backpressure();
    int sent;
    sent = 0;
    hold_requests++;
    while (sent < 50) begin
      compose_form(pick_kind(20));
      sent += text_bytes.size();
      send_text($urandom_range(0, 5) == 0);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_valid_forms();
    wait_drained();
    test_invalid_values();
    wait_drained();
    test_broken_sequences();
    wait_drained();
    test_random_text(190);
    wait_drained();
    test_backpressure();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
